// ----- rtl/core/gad_pkg.sv -----
// ----------------------------------------------------------------------------
// gad_pkg
// Shared types and constants of the glyph outline alpha dilation block.
// ----------------------------------------------------------------------------
package gad_pkg;

   localparam int CFG_W   = 10;
   localparam int PIX_W   = 32;
   localparam int ALPHA_W = 8;

   // register map of the csr port
   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 10'd512;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 10'd512;

   localparam logic [ALPHA_W-1:0] OPAQUE_ALPHA = 8'hff;
   localparam logic [8:0]         FACTOR_BIAS  = 9'd33;
   localparam logic [8:0]         FACTOR_MAX   = 9'd256;
   localparam logic [PIX_W-1:0]   RGB_MASK     = 32'h00ff_ffff;

   // output queue geometry
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   // one line store entry: previous row source and destination, alpha of the
   // row above that
   typedef struct packed {
      logic [PIX_W-1:0]   source;
      logic [PIX_W-1:0]   dest;
      logic [ALPHA_W-1:0] upper_alpha;
   } line_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] dest_pixel;
      logic             last_of_item;
      logic             end_of_frame;
   } rsp_beat_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

// ----- rtl/core/gad_line_mem.sv -----
// ----------------------------------------------------------------------------
// gad_line_mem
// Line store: one write port, two registered read ports, write-first bypass.
// ----------------------------------------------------------------------------
module gad_line_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  gad_pkg::line_word_type wr_data,
   input  logic [AW-1:0]          rd_addr_a,
   input  logic [AW-1:0]          rd_addr_b,
   output gad_pkg::line_word_type rd_data_a,
   output gad_pkg::line_word_type rd_data_b
);
   import gad_pkg::*;

   line_word_type store_ff [DEPTH];
   line_word_type rd_a_ff;
   line_word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // bypass the word being written so a read of the same entry sees it
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= store_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_b_ff <= wr_data;
      end else begin
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/core/gad_pixel_calc.sv -----
// ----------------------------------------------------------------------------
// gad_pixel_calc
// Result pixel of one position: old destination off the interior, else opaque scaling or
// neighbor alpha dilation.
module gad_pixel_calc (
   input  gad_pkg::line_word_type center_word,
   input  logic [7:0]             right_alpha,
   input  logic [7:0]             left_alpha,
   input  logic [7:0]             below_alpha,
   input  logic                   interior,
   output logic [31:0]            dest_pixel
);
   import gad_pkg::*;

   logic [ALPHA_W-1:0] ca;
   logic [8:0]         factor_sum;
   logic [8:0]         factor;
   logic [16:0]        prod_r;
   logic [16:0]        prod_g;
   logic [16:0]        prod_b;
   logic [ALPHA_W-1:0] max_lr;
   logic [ALPHA_W-1:0] max_ub;
   logic [ALPHA_W-1:0] max_all;

   always_comb begin
      ca         = center_word.source[31:24];
      factor_sum = {1'b0, ca} + FACTOR_BIAS;
      factor     = (factor_sum > FACTOR_MAX) ? FACTOR_MAX : factor_sum;
      prod_r     = 17'(factor) * 17'(center_word.source[23:16]);
      prod_g     = 17'(factor) * 17'(center_word.source[15:8]);
      prod_b     = 17'(factor) * 17'(center_word.source[7:0]);
      max_lr     = (left_alpha > right_alpha) ? left_alpha : right_alpha;
      max_ub     = (center_word.upper_alpha > below_alpha) ? center_word.upper_alpha
                                                           : below_alpha;
      max_all    = (max_lr > max_ub) ? max_lr : max_ub;
      if (!interior) begin
         dest_pixel = center_word.dest;
      end else if (ca != '0) begin
         dest_pixel = {OPAQUE_ALPHA, prod_r[15:8], prod_g[15:8], prod_b[15:8]};
      end else begin
         dest_pixel = (center_word.dest & RGB_MASK) | {max_all, 24'h0};
      end
   end

endmodule

// ----- rtl/core/gad_out_fifo.sv -----
// ----------------------------------------------------------------------------
// gad_out_fifo
// Four-entry result queue taking up to two beats per cycle.
// ----------------------------------------------------------------------------
module gad_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  gad_pkg::push_type     push,
   input  gad_pkg::rsp_beat_type first_beat,
   input  gad_pkg::rsp_beat_type second_beat,
   input  logic                  pop,
   output gad_pkg::rsp_beat_type head,
   output logic                  not_empty,
   output logic                  has_room
);
   import gad_pkg::*;

   rsp_beat_type         entries_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff;
   logic [OUT_CNT_W-1:0] count_in;
   logic [OUT_CNT_W-1:0] push_count;

   always_comb begin
      push_count = OUT_CNT_W'(push.first) + OUT_CNT_W'(push.second);
      wr_ptr_in  = wr_ptr_ff + push_count[OUT_PTR_W-1:0];
      rd_ptr_in  = rd_ptr_ff + OUT_PTR_W'(pop);
      count_in   = count_ff + push_count - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entries_ff[wr_ptr_ff] <= first_beat;
      end
      if (push.second) begin
         entries_ff[wr_ptr_ff + OUT_PTR_W'(1)] <= second_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= OUT_CNT_W'(OUT_DEPTH - 2));

endmodule

// ----- rtl/core/glyph_outline_alpha_dilation.sv -----
// Timing: a beat enters the output queue at the edge that accepts its input
//   item; results lag the input by one row.
// Throughput: one item per cycle while the queue has room for two beats; items
//   of the last row push two beats each, drained by the queue's single output port.
// Reset: synchronous; clears position, left alpha and the queue, restores the
//   size registers; the line stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// glyph_outline_alpha_dilation
// Four-neighbor alpha dilation outline over a raster ARGB glyph frame, built
// around a two-read-port line store that is read one position ahead.
// ----------------------------------------------------------------------------
module glyph_outline_alpha_dilation #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] source_pixel, [63:32] old_dest_pixel
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] dest_pixel
   output logic        rsp_tlast,   // end_of_frame
   output logic [0:0]  rsp_tuser,   // [0] last_of_item
   // size registers
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);
   import gad_pkg::*;

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int CWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int CWH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   // size registers and frame position
   logic [CFG_W-1:0]   width_ff;
   logic [CFG_W-1:0]   height_ff;
   logic [XW-1:0]      col_ff;
   logic [XW-1:0]      col_in;
   logic [YW-1:0]      row_ff;
   logic [YW-1:0]      row_in;
   logic [ALPHA_W-1:0] left_alpha_ff;
   logic [ALPHA_W-1:0] left_alpha_in;

   logic [CWW-1:0] width_ext;
   logic [CWW-1:0] eff_width;
   logic [CWW-1:0] last_col_full;
   logic [CWH-1:0] height_ext;
   logic [CWH-1:0] eff_height;
   logic [CWH-1:0] last_row_full;
   logic [XW-1:0]  last_col;
   logic [YW-1:0]  last_row;
   logic           at_last_col;
   logic           at_last_row;
   logic           row_has_result;
   logic           interior;
   logic           accept;
   logic [XW-1:0]  col_next;
   logic [YW-1:0]  row_next;

   // line store ports
   logic [XW-1:0]  rd_addr_a;
   logic [XW-1:0]  rd_addr_b;
   line_word_type  rd_word_a;
   line_word_type  rd_word_b;
   line_word_type  wr_word;

   logic [PIX_W-1:0] src_pixel;
   logic [PIX_W-1:0] dst_pixel;
   logic [PIX_W-1:0] calc_pixel;

   push_type     push;
   rsp_beat_type first_beat;
   rsp_beat_type second_beat;
   rsp_beat_type head_beat;
   logic         queue_not_empty;
   logic         queue_has_room;
   logic         pop;

   assign src_pixel = req_tdata[31:0];
   assign dst_pixel = req_tdata[63:32];

   // Clamp the size registers: width 0 acts as 1, height below 2 acts as 2,
   // and both saturate at the parameter maxima.
   always_comb begin
      width_ext     = CWW'(width_ff);
      height_ext    = CWH'(height_ff);
      if (width_ext == '0) begin
         eff_width = CWW'(1);
      end else if (width_ext > CWW'(MAX_WIDTH)) begin
         eff_width = CWW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (height_ext < CWH'(2)) begin
         eff_height = CWH'(2);
      end else if (height_ext > CWH'(MAX_HEIGHT)) begin
         eff_height = CWH'(MAX_HEIGHT);
      end else begin
         eff_height = height_ext;
      end
      last_col_full = eff_width - CWW'(1);
      last_row_full = eff_height - CWH'(1);
      last_col      = last_col_full[XW-1:0];
      last_row      = last_row_full[YW-1:0];
   end

   // Position of the item now offered. Row 0 only fills the line store; every
   // later row finishes the pixel directly above it. The outline is computed
   // for pixels off all four borders only.
   always_comb begin
      accept         = req_tvalid && req_tready;
      at_last_col    = (col_ff == last_col);
      at_last_row    = (row_ff == last_row);
      row_has_result = (row_ff != '0);
      interior       = (row_ff >= YW'(2)) && (col_ff != '0) && (col_ff < last_col);
      col_next       = at_last_col ? '0 : col_ff + XW'(1);
      if (!at_last_col) begin
         row_next = row_ff;
      end else if (at_last_row) begin
         row_next = '0;
      end else begin
         row_next = row_ff + YW'(1);
      end
   end

   // Advance position; any size write restarts the frame.
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      left_alpha_in = left_alpha_ff;
      if (csr_we) begin
         col_in        = '0;
         row_in        = '0;
         left_alpha_in = '0;
      end else if (accept) begin
         col_in = col_next;
         row_in = row_next;
         if (row_has_result) begin
            left_alpha_in = rd_word_a.source[31:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_alpha_ff <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_alpha_ff <= left_alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Read one position ahead: at every edge the store is addressed with the
   // position that holds after that edge, so the registered read words always
   // belong to the item now offered (port a: this column, port b: the next).
   // The store bypasses the word written at the same edge.
   always_comb begin
      if (reset || csr_we) begin
         rd_addr_a = '0;
      end else if (accept) begin
         rd_addr_a = col_next;
      end else begin
         rd_addr_a = col_ff;
      end
      rd_addr_b = (rd_addr_a == XW'(MAX_WIDTH - 1)) ? '0 : rd_addr_a + XW'(1);
   end

   // Write back this column: the new row's pixels, and the old center alpha
   // moving up to become the upper neighbor.
   always_comb begin
      wr_word.source      = src_pixel;
      wr_word.dest        = dst_pixel;
      wr_word.upper_alpha = rd_word_a.source[31:24];
   end

   gad_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (XW)
   ) u_line_mem (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col_ff),
      .wr_data   (wr_word),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_word_a),
      .rd_data_b (rd_word_b)
   );

   gad_pixel_calc u_pixel_calc (
      .center_word (rd_word_a),
      .right_alpha (rd_word_b.source[31:24]),
      .left_alpha  (left_alpha_ff),
      .below_alpha (src_pixel[31:24]),
      .interior    (interior),
      .dest_pixel  (calc_pixel)
   );

   // First beat: the finished pixel one row up. In the last row a second beat
   // passes the item's own old destination pixel through.
   always_comb begin
      push.first               = accept && row_has_result;
      push.second              = accept && row_has_result && at_last_row;
      first_beat.dest_pixel    = calc_pixel;
      first_beat.last_of_item  = !at_last_row;
      first_beat.end_of_frame  = 1'b0;
      second_beat.dest_pixel   = dst_pixel;
      second_beat.last_of_item = 1'b1;
      second_beat.end_of_frame = at_last_col;
   end

   gad_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_beat  (first_beat),
      .second_beat (second_beat),
      .pop         (pop),
      .head        (head_beat),
      .not_empty   (queue_not_empty),
      .has_room    (queue_has_room)
   );

   // hold off input unless two beats fit in the queue
   assign req_tready = queue_has_room && !reset;
   assign rsp_tvalid = queue_not_empty;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = head_beat.dest_pixel;
   assign rsp_tlast  = head_beat.end_of_frame;
   assign rsp_tuser  = head_beat.last_of_item;

   // ---------------------------------------------------------------- checks
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col)
      else $error("column position beyond the row");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (col_ff == '0) && (row_ff == '0) && (left_alpha_ff == '0))
      else $error("size write did not restart the frame");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_we && at_last_col && at_last_row) |=>
         (col_ff == '0) && (row_ff == '0))
      else $error("frame did not wrap after its last item");

   a_first_row_silent: assert property (@(posedge clock) disable iff (reset)
      (row_ff == '0) |-> !push.first && !push.second)
      else $error("first row produced a result");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("end of frame on a beat that is not last of its item");

endmodule
